FILE: rtl/dnd_pkg.sv
// ----------------------------------------------------------------------------
// dnd_pkg
// Shared operation codes and the sideband word that travels with each item
// through the dual number pipeline.
// ----------------------------------------------------------------------------
package dnd_pkg;

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_NEG = 3'd4;

	typedef struct packed {
		logic [2:0] mode;
		logic       lt;
		logic       eq;
		logic       last;
		logic       ovf;
		logic       dz;
		logic       qv_neg;
		logic       qg_neg;
		logic       qv_ovf;
		logic       qg_ovf;
	} side_t;

endpackage

FILE: rtl/dnd_front.sv
// ----------------------------------------------------------------------------
// dnd_front
// Five pipeline stages: operand magnitudes, products, gradient numerator,
// its magnitude, then rounding, saturation and divider setup.
// ----------------------------------------------------------------------------
module dnd_front import dnd_pkg::*; #(
	parameter int WORD_BITS     = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [2:0]                    mode,
	input  logic signed [WORD_BITS-1:0]   a_value,
	input  logic signed [WORD_BITS-1:0]   a_grad,
	input  logic signed [WORD_BITS-1:0]   b_value,
	input  logic signed [WORD_BITS-1:0]   b_grad,
	input  logic                          last_element,
	input  logic [4:0]                    en,
	output logic [4:0]                    vld,
	output side_t                         side,
	output logic [WORD_BITS-1:0]          res_v,
	output logic [WORD_BITS-1:0]          res_g,
	output logic [WORD_BITS-1:0]          rem_v,
	output logic [WORD_BITS-1:0]          numl_v,
	output logic [WORD_BITS-1:0]          den_v,
	output logic [2*WORD_BITS-1:0]        rem_g,
	output logic [WORD_BITS-1:0]          numl_g,
	output logic [2*WORD_BITS-1:0]        den_g
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int DW = 2 * WORD_BITS;
	localparam int GW = 2 * WORD_BITS + 2;
	localparam int MW = 2 * WORD_BITS + 2;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	function automatic logic [W-1:0] abs_f(input logic [W-1:0] x);
		return x[W-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic logic [W:0] sat_f(input logic neg, input logic [MW-1:0] mag,
		input logic pre);
		logic [MW-1:0] lim;
		logic [W-1:0]  low;
		logic [W:0]    r;
		lim = MW'(1) << (W - 1);
		low = mag[W-1:0];
		if (!neg) begin
			r = (pre || mag >= lim) ? {1'b1, MAXV} : {1'b0, low};
		end else begin
			r = (pre || mag > lim) ? {1'b1, MINV} : {1'b0, ~low + 1'b1};
		end
		return r;
	endfunction

	// Stage 1
	logic              vld_s1, lt_s1, eq_s1, last_s1;
	logic [2:0]        mode_s1;
	logic [W-1:0]      a_s1, ag_s1, b_s1, bg_s1;
	logic [W-1:0]      am_s1, agm_s1, bm_s1, bgm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en[0]) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mode_s1 <= mode;
			a_s1    <= a_value;
			ag_s1   <= a_grad;
			b_s1    <= b_value;
			bg_s1   <= b_grad;
			am_s1   <= abs_f(a_value);
			agm_s1  <= abs_f(a_grad);
			bm_s1   <= abs_f(b_value);
			bgm_s1  <= abs_f(b_grad);
			lt_s1   <= a_value < b_value;
			eq_s1   <= a_value == b_value;
			last_s1 <= last_element;
		end
	end

	// Stage 2
	logic signed [W:0] ax, bx, agx, bgx, sv_c, sg_c;
	logic              vld_s2, lt_s2, eq_s2, last_s2, t1n_s2, t2n_s2, vneg_s2;
	logic [2:0]        mode_s2;
	logic [DW-1:0]     p1_s2, p2_s2, pab_s2, pbb_s2;
	logic [W-1:0]      am_s2, bm_s2;
	logic [W:0]        sv_s2, sg_s2;

	assign ax  = {a_s1[W-1], a_s1};
	assign bx  = {b_s1[W-1], b_s1};
	assign agx = {ag_s1[W-1], ag_s1};
	assign bgx = {bg_s1[W-1], bg_s1};

	always_comb begin
		unique case (mode_s1)
			MODE_ADD: begin
				sv_c = ax + bx;
				sg_c = agx + bgx;
			end
			MODE_SUB: begin
				sv_c = ax - bx;
				sg_c = agx - bgx;
			end
			MODE_NEG: begin
				sv_c = -ax;
				sg_c = -agx;
			end
			default: begin
				sv_c = '0;
				sg_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en[1]) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mode_s2 <= mode_s1;
			lt_s2   <= lt_s1;
			eq_s2   <= eq_s1;
			last_s2 <= last_s1;
			p1_s2   <= DW'(agm_s1) * DW'(bm_s1);
			p2_s2   <= DW'(am_s1) * DW'(bgm_s1);
			pab_s2  <= DW'(am_s1) * DW'(bm_s1);
			pbb_s2  <= DW'(bm_s1) * DW'(bm_s1);
			t1n_s2  <= ag_s1[W-1] ^ b_s1[W-1];
			t2n_s2  <= a_s1[W-1] ^ bg_s1[W-1];
			vneg_s2 <= a_s1[W-1] ^ b_s1[W-1];
			am_s2   <= am_s1;
			bm_s2   <= bm_s1;
			sv_s2   <= sv_c;
			sg_s2   <= sg_c;
		end
	end

	// Stage 3
	logic [GW-1:0]     x_c, y_c;
	logic              sub_c;
	logic              vld_s3, lt_s3, eq_s3, last_s3, vneg_s3;
	logic [2:0]        mode_s3;
	logic [GW-1:0]     gsum_s3;
	logic [DW-1:0]     pab_s3, pbb_s3;
	logic [W-1:0]      am_s3, bm_s3;
	logic [W:0]        sv_s3, sg_s3;

	assign sub_c = (mode_s2 == MODE_DIV) ^ t2n_s2;
	assign x_c   = t1n_s2 ? -GW'(p1_s2) : GW'(p1_s2);
	assign y_c   = sub_c ? -GW'(p2_s2) : GW'(p2_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en[2]) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			mode_s3 <= mode_s2;
			lt_s3   <= lt_s2;
			eq_s3   <= eq_s2;
			last_s3 <= last_s2;
			gsum_s3 <= x_c + y_c;
			pab_s3  <= pab_s2;
			pbb_s3  <= pbb_s2;
			vneg_s3 <= vneg_s2;
			am_s3   <= am_s2;
			bm_s3   <= bm_s2;
			sv_s3   <= sv_s2;
			sg_s3   <= sg_s2;
		end
	end

	// Stage 4
	logic [GW-1:0]     gabs_c;
	logic [W:0]        svm_c, sgm_c;
	logic              vld_s4, lt_s4, eq_s4, last_s4, vneg_s4, gneg_s4;
	logic [2:0]        mode_s4;
	logic [DW-1:0]     gmag_s4, pab_s4, pbb_s4;
	logic [W-1:0]      am_s4, bm_s4;
	logic [W:0]        addv_s4, addg_s4;

	assign gabs_c = gsum_s3[GW-1] ? (~gsum_s3 + 1'b1) : gsum_s3;
	assign svm_c  = sv_s3[W] ? (~sv_s3 + 1'b1) : sv_s3;
	assign sgm_c  = sg_s3[W] ? (~sg_s3 + 1'b1) : sg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en[3]) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			mode_s4 <= mode_s3;
			lt_s4   <= lt_s3;
			eq_s4   <= eq_s3;
			last_s4 <= last_s3;
			gneg_s4 <= gsum_s3[GW-1];
			gmag_s4 <= DW'(gabs_c);
			pab_s4  <= pab_s3;
			pbb_s4  <= pbb_s3;
			vneg_s4 <= vneg_s3;
			am_s4   <= am_s3;
			bm_s4   <= bm_s3;
			addv_s4 <= sat_f(sv_s3[W], MW'(svm_c), 1'b0);
			addg_s4 <= sat_f(sg_s3[W], MW'(sgm_c), 1'b0);
		end
	end

	// Stage 5
	logic [MW-1:0]     half_c, rvm_c, rgm_c;
	logic [W:0]        mv_c, mg_c;
	logic [W-1:0]      rv_c, rg_c;
	logic              ovf_c;
	logic [W+F-1:0]    nv_c, nvh_c;
	logic [DW+F-1:0]   ng_c, ngh_c;
	logic              vld_s5;
	side_t             side_s5;
	logic [W-1:0]      rv_s5, rg_s5, remv_s5, numv_s5, denv_s5, numg_s5;
	logic [DW-1:0]     remg_s5, deng_s5;

	assign half_c = MW'(1) << (F - 1);
	assign rvm_c  = (MW'(pab_s4) + half_c) >> F;
	assign rgm_c  = (MW'(gmag_s4) + half_c) >> F;
	assign mv_c   = sat_f(vneg_s4, rvm_c, 1'b0);
	assign mg_c   = sat_f(gneg_s4, rgm_c, 1'b0);
	assign nv_c   = (W+F)'(am_s4) << F;
	assign nvh_c  = nv_c >> W;
	assign ng_c   = (DW+F)'(gmag_s4) << F;
	assign ngh_c  = ng_c >> W;

	always_comb begin
		unique case (mode_s4) inside
			MODE_ADD, MODE_SUB, MODE_NEG: begin
				rv_c  = addv_s4[W-1:0];
				rg_c  = addg_s4[W-1:0];
				ovf_c = addv_s4[W] | addg_s4[W];
			end
			MODE_MUL: begin
				rv_c  = mv_c[W-1:0];
				rg_c  = mg_c[W-1:0];
				ovf_c = mv_c[W] | mg_c[W];
			end
			default: begin
				rv_c  = '0;
				rg_c  = '0;
				ovf_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en[4]) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			side_s5.mode   <= mode_s4;
			side_s5.lt     <= lt_s4;
			side_s5.eq     <= eq_s4;
			side_s5.last   <= last_s4;
			side_s5.ovf    <= ovf_c;
			side_s5.dz     <= (mode_s4 == MODE_DIV) && (bm_s4 == '0);
			side_s5.qv_neg <= vneg_s4;
			side_s5.qg_neg <= gneg_s4;
			side_s5.qv_ovf <= nvh_c >= (W+F)'(bm_s4);
			side_s5.qg_ovf <= ngh_c >= (DW+F)'(pbb_s4);
			rv_s5          <= rv_c;
			rg_s5          <= rg_c;
			remv_s5        <= W'(nvh_c);
			numv_s5        <= nv_c[W-1:0];
			denv_s5        <= bm_s4;
			remg_s5        <= DW'(ngh_c);
			numg_s5        <= ng_c[W-1:0];
			deng_s5        <= pbb_s4;
		end
	end

	assign vld    = {vld_s5, vld_s4, vld_s3, vld_s2, vld_s1};
	assign side   = side_s5;
	assign res_v  = rv_s5;
	assign res_g  = rg_s5;
	assign rem_v  = remv_s5;
	assign numl_v = numv_s5;
	assign den_v  = denv_s5;
	assign rem_g  = remg_s5;
	assign numl_g = numg_s5;
	assign den_g  = deng_s5;

endmodule

FILE: rtl/dnd_div.sv
// ----------------------------------------------------------------------------
// dnd_div
// Pipelined restoring divider, one quotient bit per stage, run for the value
// and the gradient quotients side by side.
// ----------------------------------------------------------------------------
module dnd_div import dnd_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [WORD_BITS-1:0]          en,
	output logic [WORD_BITS-1:0]          vld,
	input  logic                          vld_in,
	input  side_t                         side_in,
	input  logic [WORD_BITS-1:0]          rv_in,
	input  logic [WORD_BITS-1:0]          rg_in,
	input  logic [WORD_BITS-1:0]          remv_in,
	input  logic [WORD_BITS-1:0]          numv_in,
	input  logic [WORD_BITS-1:0]          denv_in,
	input  logic [2*WORD_BITS-1:0]        remg_in,
	input  logic [WORD_BITS-1:0]          numg_in,
	input  logic [2*WORD_BITS-1:0]        deng_in,
	output side_t                         side_out,
	output logic [WORD_BITS-1:0]          rv_out,
	output logic [WORD_BITS-1:0]          rg_out,
	output logic [WORD_BITS-1:0]          qv,
	output logic [WORD_BITS-1:0]          qg
);

	localparam int W  = WORD_BITS;
	localparam int DW = 2 * WORD_BITS;

	logic [W-1:0]  vld_s;
	side_t         side_s [W];
	logic [W-1:0]  rv_s [W], rg_s [W], remv_s [W], numv_s [W], denv_s [W], qv_s [W];
	logic [W-1:0]  numg_s [W], qg_s [W];
	logic [DW-1:0] remg_s [W], deng_s [W];

	side_t         side_p [W];
	logic [W-1:0]  rv_p [W], rg_p [W], remv_p [W], numv_p [W], denv_p [W], qv_p [W];
	logic [W-1:0]  numg_p [W], qg_p [W];
	logic [DW-1:0] remg_p [W], deng_p [W];

	logic [W-1:0]  remv_n [W], numv_n [W], qv_n [W], numg_n [W], qg_n [W];
	logic [DW-1:0] remg_n [W];

	always_comb begin
		side_p[0] = side_in;
		rv_p[0]   = rv_in;
		rg_p[0]   = rg_in;
		remv_p[0] = remv_in;
		numv_p[0] = numv_in;
		denv_p[0] = denv_in;
		qv_p[0]   = '0;
		remg_p[0] = remg_in;
		numg_p[0] = numg_in;
		deng_p[0] = deng_in;
		qg_p[0]   = '0;
		for (int k = 1; k < W; k++) begin
			side_p[k] = side_s[k-1];
			rv_p[k]   = rv_s[k-1];
			rg_p[k]   = rg_s[k-1];
			remv_p[k] = remv_s[k-1];
			numv_p[k] = numv_s[k-1];
			denv_p[k] = denv_s[k-1];
			qv_p[k]   = qv_s[k-1];
			remg_p[k] = remg_s[k-1];
			numg_p[k] = numg_s[k-1];
			deng_p[k] = deng_s[k-1];
			qg_p[k]   = qg_s[k-1];
		end
	end

	always_comb begin
		logic [W+1:0]  dv;
		logic [DW+1:0] dg;
		for (int k = 0; k < W; k++) begin
			dv = {1'b0, remv_p[k], numv_p[k][W-1]} - {2'b00, denv_p[k]};
			remv_n[k] = dv[W+1] ? {remv_p[k][W-2:0], numv_p[k][W-1]} : dv[W-1:0];
			numv_n[k] = numv_p[k] << 1;
			qv_n[k]   = {qv_p[k][W-2:0], ~dv[W+1]};
			dg = {1'b0, remg_p[k], numg_p[k][W-1]} - {2'b00, deng_p[k]};
			remg_n[k] = dg[DW+1] ? {remg_p[k][DW-2:0], numg_p[k][W-1]} : dg[DW-1:0];
			numg_n[k] = numg_p[k] << 1;
			qg_n[k]   = {qg_p[k][W-2:0], ~dg[DW+1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < W; k++) begin
				if (en[k]) begin
					vld_s[k] <= (k == 0) ? vld_in : vld_s[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < W; k++) begin
			if (en[k]) begin
				side_s[k] <= side_p[k];
				rv_s[k]   <= rv_p[k];
				rg_s[k]   <= rg_p[k];
				remv_s[k] <= remv_n[k];
				numv_s[k] <= numv_n[k];
				denv_s[k] <= denv_p[k];
				qv_s[k]   <= qv_n[k];
				remg_s[k] <= remg_n[k];
				numg_s[k] <= numg_n[k];
				deng_s[k] <= deng_p[k];
				qg_s[k]   <= qg_n[k];
			end
		end
	end

	assign vld      = vld_s;
	assign side_out = side_s[W-1];
	assign rv_out   = rv_s[W-1];
	assign rg_out   = rg_s[W-1];
	assign qv       = qv_s[W-1];
	assign qg       = qg_s[W-1];

endmodule

FILE: rtl/dnd_back.sv
// ----------------------------------------------------------------------------
// dnd_back
// Output register: saturates the quotients, picks the result for the mode
// and holds the finished word until it is taken.
// ----------------------------------------------------------------------------
module dnd_back import dnd_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  side_t                         side_in,
	input  logic [WORD_BITS-1:0]          rv_in,
	input  logic [WORD_BITS-1:0]          rg_in,
	input  logic [WORD_BITS-1:0]          qv,
	input  logic [WORD_BITS-1:0]          qg,
	output logic                          out_valid,
	output logic signed [WORD_BITS-1:0]   result_value,
	output logic signed [WORD_BITS-1:0]   result_grad,
	output logic                          a_less_than_b,
	output logic                          a_equals_b,
	output logic                          overflow,
	output logic                          divide_by_zero,
	output logic                          last_out
);

	localparam int W = WORD_BITS;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	function automatic logic [W:0] sat_q(input logic neg, input logic [W-1:0] mag,
		input logic pre);
		logic [W:0] r;
		if (!neg) begin
			r = (pre || mag[W-1]) ? {1'b1, MAXV} : {1'b0, mag};
		end else begin
			r = (pre || mag > MINV) ? {1'b1, MINV} : {1'b0, ~mag + 1'b1};
		end
		return r;
	endfunction

	logic [W:0]   sv_c, sg_c;
	logic [W-1:0] val_c, grd_c;
	logic         ovf_c;

	logic         vld_q, lt_q, eq_q, ovf_q, dz_q, last_q;
	logic [W-1:0] val_q, grd_q;

	assign sv_c = sat_q(side_in.qv_neg, qv, side_in.qv_ovf);
	assign sg_c = sat_q(side_in.qg_neg, qg, side_in.qg_ovf);

	always_comb begin
		if (side_in.mode == MODE_DIV) begin
			val_c = sv_c[W-1:0];
			grd_c = sg_c[W-1:0];
			ovf_c = sv_c[W] | sg_c[W];
		end else begin
			val_c = rv_in;
			grd_c = rg_in;
			ovf_c = side_in.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_q  <= val_c;
			grd_q  <= grd_c;
			lt_q   <= side_in.lt;
			eq_q   <= side_in.eq;
			ovf_q  <= ovf_c;
			dz_q   <= side_in.dz;
			last_q <= side_in.last;
		end
	end

	assign out_valid      = vld_q;
	assign result_value   = val_q;
	assign result_grad    = grd_q;
	assign a_less_than_b  = lt_q;
	assign a_equals_b     = eq_q;
	assign overflow       = ovf_q;
	assign divide_by_zero = dz_q;
	assign last_out       = last_q;

endmodule

FILE: rtl/dual_number_derivative_alu_unit.sv
// An accepted input word passes the front stages, the divider stages and the output register in that order.
// Throughput: one word per cycle while out_ready holds; the divider retires one quotient bit per stage.
// Each stage holds its word while the next stage is full and stalled, so bubbles close up.
// Reset clears all valid bits at once; payload registers are not reset.
// ----------------------------------------------------------------------------
// dual_number_derivative_alu_unit
// Dual number add, subtract, multiply, divide and negate in signed fixed point
// with saturation and value comparison flags.
// ----------------------------------------------------------------------------
module dual_number_derivative_alu_unit import dnd_pkg::*; #(
	parameter int WORD_BITS     = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    mode,
	input  logic signed [WORD_BITS-1:0]   a_value,
	input  logic signed [WORD_BITS-1:0]   a_grad,
	input  logic signed [WORD_BITS-1:0]   b_value,
	input  logic signed [WORD_BITS-1:0]   b_grad,
	input  logic                          last_element,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [WORD_BITS-1:0]   result_value,
	output logic signed [WORD_BITS-1:0]   result_grad,
	output logic                          a_less_than_b,
	output logic                          a_equals_b,
	output logic                          overflow,
	output logic                          divide_by_zero,
	output logic                          last_out
);

	localparam int W  = WORD_BITS;
	localparam int DW = 2 * WORD_BITS;
	localparam int L  = WORD_BITS + 6;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic [L-1:0]  vld, en;
	side_t         side_f, side_d;
	logic [W-1:0]  rv_f, rg_f, remv_f, numv_f, denv_f, numg_f;
	logic [DW-1:0] remg_f, deng_f;
	logic [W-1:0]  rv_d, rg_d, qv_d, qg_d;

	for (genvar k = 0; k < L - 1; k++) begin : g_en
		assign en[k] = !vld[k] || en[k+1];
	end
	assign en[L-1]  = !vld[L-1] || out_ready;
	assign in_ready = en[0];

	dnd_front #(
		.WORD_BITS     (WORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.mode         (mode),
		.a_value      (a_value),
		.a_grad       (a_grad),
		.b_value      (b_value),
		.b_grad       (b_grad),
		.last_element (last_element),
		.en           (en[4:0]),
		.vld          (vld[4:0]),
		.side         (side_f),
		.res_v        (rv_f),
		.res_g        (rg_f),
		.rem_v        (remv_f),
		.numl_v       (numv_f),
		.den_v        (denv_f),
		.rem_g        (remg_f),
		.numl_g       (numg_f),
		.den_g        (deng_f)
	);

	dnd_div #(
		.WORD_BITS (WORD_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en[W+4:5]),
		.vld      (vld[W+4:5]),
		.vld_in   (vld[4]),
		.side_in  (side_f),
		.rv_in    (rv_f),
		.rg_in    (rg_f),
		.remv_in  (remv_f),
		.numv_in  (numv_f),
		.denv_in  (denv_f),
		.remg_in  (remg_f),
		.numg_in  (numg_f),
		.deng_in  (deng_f),
		.side_out (side_d),
		.rv_out   (rv_d),
		.rg_out   (rg_d),
		.qv       (qv_d),
		.qg       (qg_d)
	);

	dnd_back #(
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en[L-1]),
		.vld_in         (vld[W+4]),
		.side_in        (side_d),
		.rv_in          (rv_d),
		.rg_in          (rg_d),
		.qv             (qv_d),
		.qg             (qg_d),
		.out_valid      (vld[L-1]),
		.result_value   (result_value),
		.result_grad    (result_grad),
		.a_less_than_b  (a_less_than_b),
		.a_equals_b     (a_equals_b),
		.overflow       (overflow),
		.divide_by_zero (divide_by_zero),
		.last_out       (last_out)
	);

	assign out_valid = vld[L-1];

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input stalled while the output stage is empty.");

	a_dz_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> overflow)
		else $error("Division by zero without overflow.");

	a_ovf_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> (result_value == MAXV) || (result_value == MINV) ||
			(result_grad == MAXV) || (result_grad == MINV))
		else $error("Overflow flagged but no result sits at a bound.");

	a_cmp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && a_equals_b |-> !a_less_than_b)
		else $error("Equal and less-than flags both set.");

endmodule
